FILE: hdl/aclm_pkg.sv
package aclm_pkg;

   localparam int NODES_DEF    = 4096;
   localparam int ALPHABET_DEF = 26;

   localparam int OP_W   = 2;
   localparam int SYM_W  = 5;
   localparam int LEN_W  = 12;
   localparam int POS_W  = 16;
   localparam int STAT_W = 2;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_BUILD  = 2'd1;
   localparam logic [OP_W-1:0] OP_SCAN   = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_ORDER = 2'd2;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  position;
      logic [LEN_W-1:0]  match_len;
      logic [POS_W-1:0]  match_start;
   } rsp_type;

endpackage

FILE: hdl/aclm_ram.sv
module aclm_ram
#(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
)
(
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/aclm_rsp.sv
module aclm_rsp
   import aclm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsp_type           data,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [POS_W-1:0]  rsp_position,
   output logic [LEN_W-1:0]  rsp_match_len,
   output logic [POS_W-1:0]  rsp_match_start
);

   logic    valid_ff, valid_in;
   rsp_type word_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = push ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (push && space) begin
         word_ff <= data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = word_ff.status;
   assign rsp_position    = word_ff.position;
   assign rsp_match_len   = word_ff.match_len;
   assign rsp_match_start = word_ff.match_start;

endmodule

FILE: hdl/aho_corasick_longest_match.sv
// Aho-Corasick longest-match scanner. After reset the block sweeps its goto
// store to zero, one entry per cycle; req_ready stays low until then. Insert
// words (op 0) grow the trie, last closing a pattern; one build word (op 1)
// runs the breadth-first pass that sets failure links, completes the goto
// table and spreads match lengths; scan words (op 2) then step the automaton,
// one response per word. Everything lives in synchronous memories with one
// read port each, so one word is in flight at a time: insert waits on the
// goto read, scan on the dependent goto then length reads, and build on the
// one goto read port, walked per letter.
module aho_corasick_longest_match
   import aclm_pkg::*;
#(
   parameter int NODES    = NODES_DEF,
   parameter int ALPHABET = ALPHABET_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_op,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [POS_W-1:0]  rsp_position,
   output logic [LEN_W-1:0]  rsp_match_len,
   output logic [POS_W-1:0]  rsp_match_start
);

   localparam int GOTO_DEPTH = NODES * ALPHABET;
   localparam int GW = $clog2(GOTO_DEPTH);
   localparam int NW = $clog2(NODES);
   localparam int AW = $clog2(ALPHABET);

   // sequencer states
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DISP  = 4'd2;
   localparam logic [3:0] S_INS   = 4'd3;
   localparam logic [3:0] S_SCAN1 = 4'd4;
   localparam logic [3:0] S_SCAN2 = 4'd5;
   localparam logic [3:0] S_BR_RD = 4'd6;
   localparam logic [3:0] S_BR_WR = 4'd7;
   localparam logic [3:0] S_BQ_RD = 4'd8;
   localparam logic [3:0] S_BQ_U  = 4'd9;
   localparam logic [3:0] S_BF    = 4'd10;
   localparam logic [3:0] S_BM    = 4'd11;
   localparam logic [3:0] S_BG_U  = 4'd12;
   localparam logic [3:0] S_BG_F  = 4'd13;
   localparam logic [3:0] S_BG_W  = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   logic [3:0]       st_ff, st_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic             last_ff, last_in;
   logic [NW-1:0]    node_count_ff, node_count_in;
   logic [NW-1:0]    ins_node_ff, ins_node_in;
   logic [LEN_W-1:0] ins_depth_ff, ins_depth_in;
   logic [NW-1:0]    scan_node_ff, scan_node_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             built_ff, built_in;
   logic             drop_ff, drop_in;
   logic [GW-1:0]    cnt_ff, cnt_in;
   rsp_type          res_ff, res_in;
   logic [NW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0]    i_ff, i_in;
   logic [NW-1:0]    u_ff, u_in, t_ff, t_in;
   logic [LEN_W-1:0] lenu_ff, lenu_in;
   logic [GW-1:0]    ubase_ff, ubase_in, fbase_ff, fbase_in, gaddr_ff, gaddr_in;

   // memory ports
   logic             goto_we, fail_we, mlen_we, queue_we;
   logic [GW-1:0]    goto_waddr, goto_raddr;
   logic [NW-1:0]    goto_wdata, goto_rdata;
   logic [NW-1:0]    fail_waddr, fail_raddr, fail_wdata, fail_rdata;
   logic [NW-1:0]    mlen_waddr, mlen_raddr;
   logic [LEN_W-1:0] mlen_wdata, mlen_rdata;
   logic [NW-1:0]    queue_waddr, queue_raddr, queue_wdata, queue_rdata;

   logic             rsp_space, rsp_push;
   logic             bad_sym;
   logic [NW:0]      count_next;
   logic [NW-1:0]    next_node;
   logic [LEN_W-1:0] depth_next;

   assign req_ready  = (st_ff == S_IDLE);
   assign bad_sym    = ({4'b0, sym_ff} >= 9'(ALPHABET));
   assign count_next = {1'b0, node_count_ff} + (NW+1)'(1);

   always_comb begin
      st_in         = st_ff;
      op_in         = op_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      node_count_in = node_count_ff;
      ins_node_in   = ins_node_ff;
      ins_depth_in  = ins_depth_ff;
      scan_node_in  = scan_node_ff;
      pos_in        = pos_ff;
      built_in      = built_ff;
      drop_in       = drop_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      i_in          = i_ff;
      u_in          = u_ff;
      t_in          = t_ff;
      lenu_in       = lenu_ff;
      ubase_in      = ubase_ff;
      fbase_in      = fbase_ff;
      gaddr_in      = gaddr_ff;
      rsp_push      = 1'b0;
      next_node     = goto_rdata;
      depth_next    = (ins_depth_ff < LEN_MAX) ? ins_depth_ff + LEN_W'(1) : ins_depth_ff;

      goto_we     = 1'b0;
      goto_waddr  = gaddr_ff;
      goto_wdata  = '0;
      goto_raddr  = gaddr_ff;
      fail_we     = 1'b0;
      fail_waddr  = t_ff;
      fail_wdata  = '0;
      fail_raddr  = u_ff;
      mlen_we     = 1'b0;
      mlen_waddr  = u_ff;
      mlen_wdata  = '0;
      mlen_raddr  = u_ff;
      queue_we    = 1'b0;
      queue_waddr = tail_ff;
      queue_wdata = t_ff;
      queue_raddr = head_ff;

      case (st_ff)
         S_CLEAR: begin
            goto_we    = 1'b1;
            goto_waddr = cnt_ff;
            fail_we    = 1'b1;
            fail_waddr = cnt_ff[NW-1:0];
            mlen_we    = 1'b1;
            mlen_waddr = cnt_ff[NW-1:0];
            cnt_in     = cnt_ff + GW'(1);
            if (cnt_ff == GW'(GOTO_DEPTH - 1)) begin
               st_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_op;
               sym_in  = req_symbol;
               last_in = req_last;
               st_in   = S_DISP;
            end
         end
         S_DISP: begin
            res_in = '0;
            st_in  = S_OUT;
            case (op_ff)
               OP_INSERT: begin
                  if (built_ff || bad_sym) begin
                     res_in.status = ST_ORDER;
                  end else if (drop_ff) begin
                     res_in.status = ST_FULL;
                     if (last_ff) begin
                        drop_in = 1'b0;
                     end
                  end else begin
                     gaddr_in   = GW'(ins_node_ff) * GW'(ALPHABET) + GW'(sym_ff);
                     goto_raddr = gaddr_in;
                     st_in      = S_INS;
                  end
               end
               OP_BUILD: begin
                  if (built_ff || ins_depth_ff != '0 || drop_ff) begin
                     res_in.status = ST_ORDER;
                  end else begin
                     i_in    = '0;
                     head_in = '0;
                     tail_in = '0;
                     st_in   = S_BR_RD;
                  end
               end
               OP_SCAN: begin
                  if (!built_ff || bad_sym) begin
                     res_in.status = ST_ORDER;
                  end else begin
                     goto_raddr = GW'(scan_node_ff) * GW'(ALPHABET) + GW'(sym_ff);
                     st_in      = S_SCAN1;
                  end
               end
               default: begin
                  res_in.status = ST_ORDER;
               end
            endcase
         end
         S_INS: begin
            st_in = S_OUT;
            if (goto_rdata == '0 && count_next >= (NW+1)'(NODES)) begin
               res_in.status = ST_FULL;
               ins_node_in   = '0;
               ins_depth_in  = '0;
               drop_in       = !last_ff;
            end else begin
               if (goto_rdata == '0) begin
                  next_node     = count_next[NW-1:0];
                  node_count_in = next_node;
                  goto_we       = 1'b1;
                  goto_wdata    = next_node;
               end
               if (last_ff) begin
                  mlen_we      = 1'b1;
                  mlen_waddr   = next_node;
                  mlen_wdata   = depth_next;
                  ins_node_in  = '0;
                  ins_depth_in = '0;
               end else begin
                  ins_node_in  = next_node;
                  ins_depth_in = depth_next;
               end
            end
         end
         S_SCAN1: begin
            scan_node_in = goto_rdata;
            pos_in       = pos_ff + POS_W'(1);
            mlen_raddr   = goto_rdata;
            st_in        = S_SCAN2;
         end
         S_SCAN2: begin
            res_in.position    = pos_ff;
            res_in.match_len   = mlen_rdata;
            res_in.match_start = pos_ff - POS_W'(mlen_rdata);
            if (last_ff) begin
               scan_node_in = '0;
               pos_in       = '0;
            end
            st_in = S_OUT;
         end
         // root row: children fail to the root and seed the queue
         S_BR_RD: begin
            goto_raddr = GW'(i_ff);
            st_in      = S_BR_WR;
         end
         S_BR_WR: begin
            if (goto_rdata != '0) begin
               fail_we     = 1'b1;
               fail_waddr  = goto_rdata;
               fail_wdata  = '0;
               queue_we    = 1'b1;
               queue_wdata = goto_rdata;
               tail_in     = tail_ff + NW'(1);
            end
            if (i_ff == AW'(ALPHABET - 1)) begin
               st_in = S_BQ_RD;
            end else begin
               i_in  = i_ff + AW'(1);
               st_in = S_BR_RD;
            end
         end
         S_BQ_RD: begin
            if (head_ff == tail_ff) begin
               built_in = 1'b1;
               st_in    = S_OUT;
            end else begin
               head_in = head_ff + NW'(1);
               st_in   = S_BQ_U;
            end
         end
         S_BQ_U: begin
            u_in       = queue_rdata;
            fail_raddr = queue_rdata;
            mlen_raddr = queue_rdata;
            ubase_in   = GW'(queue_rdata) * GW'(ALPHABET);
            st_in      = S_BF;
         end
         S_BF: begin
            lenu_in    = mlen_rdata;
            mlen_raddr = fail_rdata;
            fbase_in   = GW'(fail_rdata) * GW'(ALPHABET);
            i_in       = '0;
            st_in      = S_BM;
         end
         S_BM: begin
            if (mlen_rdata > lenu_ff) begin
               mlen_we    = 1'b1;
               mlen_waddr = u_ff;
               mlen_wdata = mlen_rdata;
            end
            st_in = S_BG_U;
         end
         S_BG_U: begin
            goto_raddr = ubase_ff + GW'(i_ff);
            st_in      = S_BG_F;
         end
         S_BG_F: begin
            t_in       = goto_rdata;
            goto_raddr = fbase_ff + GW'(i_ff);
            st_in      = S_BG_W;
         end
         S_BG_W: begin
            if (t_ff != '0) begin
               fail_we     = 1'b1;
               fail_waddr  = t_ff;
               fail_wdata  = goto_rdata;
               queue_we    = 1'b1;
               queue_wdata = t_ff;
               tail_in     = tail_ff + NW'(1);
            end else begin
               goto_we    = 1'b1;
               goto_waddr = ubase_ff + GW'(i_ff);
               goto_wdata = goto_rdata;
            end
            if (i_ff == AW'(ALPHABET - 1)) begin
               st_in = S_BQ_RD;
            end else begin
               i_in  = i_ff + AW'(1);
               st_in = S_BG_U;
            end
         end
         S_OUT: begin
            if (rsp_space) begin
               rsp_push = 1'b1;
               st_in    = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_CLEAR;
         cnt_ff        <= '0;
         node_count_ff <= '0;
         ins_node_ff   <= '0;
         ins_depth_ff  <= '0;
         scan_node_ff  <= '0;
         pos_ff        <= '0;
         built_ff      <= 1'b0;
         drop_ff       <= 1'b0;
         head_ff       <= '0;
         tail_ff       <= '0;
      end else begin
         st_ff         <= st_in;
         cnt_ff        <= cnt_in;
         node_count_ff <= node_count_in;
         ins_node_ff   <= ins_node_in;
         ins_depth_ff  <= ins_depth_in;
         scan_node_ff  <= scan_node_in;
         pos_ff        <= pos_in;
         built_ff      <= built_in;
         drop_ff       <= drop_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
      op_ff    <= op_in;
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
      i_ff     <= i_in;
      u_ff     <= u_in;
      t_ff     <= t_in;
      lenu_ff  <= lenu_in;
      ubase_ff <= ubase_in;
      fbase_ff <= fbase_in;
      gaddr_ff <= gaddr_in;
   end

   aclm_ram #(.WIDTH(NW), .DEPTH(GOTO_DEPTH)) u_goto (
      .clock (clock),
      .we    (goto_we),
      .waddr (goto_waddr),
      .wdata (goto_wdata),
      .raddr (goto_raddr),
      .rdata (goto_rdata)
   );

   aclm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
      .clock (clock),
      .we    (fail_we),
      .waddr (fail_waddr),
      .wdata (fail_wdata),
      .raddr (fail_raddr),
      .rdata (fail_rdata)
   );

   aclm_ram #(.WIDTH(LEN_W), .DEPTH(NODES)) u_mlen (
      .clock (clock),
      .we    (mlen_we),
      .waddr (mlen_waddr),
      .wdata (mlen_wdata),
      .raddr (mlen_raddr),
      .rdata (mlen_rdata)
   );

   aclm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
      .clock (clock),
      .we    (queue_we),
      .waddr (queue_waddr),
      .wdata (queue_wdata),
      .raddr (queue_raddr),
      .rdata (queue_rdata)
   );

   aclm_rsp u_rsp (
      .clock           (clock),
      .reset           (reset),
      .push            (rsp_push),
      .data            (res_ff),
      .space           (rsp_space),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_match_len   (rsp_match_len),
      .rsp_match_start (rsp_match_start)
   );

endmodule
